// ----- src/bxr_pkg.sv -----
// shared types and constants for the box regression refine block
`timescale 1ns / 1ps

package bxr_pkg;

   // box coordinate width in bits
   localparam int COORD_BITS = 12;
   // regression offsets are fixed 16-bit signed words
   localparam int OFFSET_BITS = 16;
   // extra fraction bits kept for the square reshape
   localparam int FINE_EXTRA = 13;
   // side scale is Q4.12
   localparam int SCALE_BITS = 16;
   localparam int IMAGE_BITS = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SQUARE_MODE = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIDE_SCALE = 2'd3;

   // configuration reset values
   localparam logic [IMAGE_BITS-1:0] IMAGE_WIDTH_RESET = 13'd640;
   localparam logic [IMAGE_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd480;
   localparam logic [SCALE_BITS-1:0] SIDE_SCALE_RESET = 16'd4096;

   typedef struct packed {
      logic [COORD_BITS-1:0]         left;
      logic [COORD_BITS-1:0]         top;
      logic [COORD_BITS-1:0]         box_width;
      logic [COORD_BITS-1:0]         box_height;
      logic signed [OFFSET_BITS-1:0] offset_left;
      logic signed [OFFSET_BITS-1:0] offset_top;
      logic signed [OFFSET_BITS-1:0] offset_right;
      logic signed [OFFSET_BITS-1:0] offset_bottom;
   } req_type;

   typedef struct packed {
      logic [14:0]        new_left;
      logic [14:0]        new_top;
      logic signed [15:0] new_right;
      logic signed [15:0] new_bottom;
      logic signed [15:0] new_width;
      logic signed [15:0] new_height;
   } rsp_type;

endpackage

// ----- src/bxr_round.sv -----
// two-stage round half away from zero of a fixed point corner
`timescale 1ns / 1ps

module bxr_round #(
   parameter int FW = 47,
   parameter int SHIFT = 26
) (
   input  logic                      clock,
   input  logic signed [FW-1:0]      in_value,
   output logic signed [FW-SHIFT:0]  out_value
);

   localparam int OW = FW - SHIFT + 1;
   localparam logic [FW-1:0] HALF = FW'(1) << (SHIFT - 1);

   logic          neg_ff;
   logic          neg_in;
   logic [FW-1:0] mag_in;
   logic [FW-1:0] sum_ff;
   logic [FW-1:0] sum_in;
   logic [FW-1:0] shifted;
   logic signed [OW-1:0] qz;
   logic signed [OW-1:0] out_ff;
   logic signed [OW-1:0] out_in;

   // magnitude plus half
   always_comb begin
      neg_in = in_value[FW-1];
      mag_in = neg_in ? FW'(-in_value) : FW'(in_value);
      sum_in = mag_in + HALF;
   end

   // truncate and restore the sign
   always_comb begin
      shifted = sum_ff >> SHIFT;
      qz = $signed({1'b0, shifted[OW-2:0]});
      out_in = neg_ff ? -qz : qz;
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      sum_ff <= sum_in;
      out_ff <= out_in;
   end

   assign out_value = out_ff;

endmodule

// ----- src/box_regression_refine_top.sv -----
// top level of the box regression refine pipeline
`timescale 1ns / 1ps

// Refines one detection box per clock: a box is taken at every edge with start high and
// busy low, and its result is shown on rsp_data with rsp_valid high for exactly one cycle,
// after it has passed through nine register stages (offset multiply, edge sums, size and
// longer side, side scale multiply, fine corners, two rounding stages, clamp, size). There
// is no backpressure: the receiver must take every result in the cycle it is shown. busy
// is a registered copy of reset: it is high while reset is held and in the cycle after it
// is released. Configuration registers are written through
// csr_we/csr_index/csr_wdata and should be changed only when no box is in flight.
module box_regression_refine_top #(
   parameter int OFFSET_FRAC_BITS = 13
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  bxr_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   output bxr_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [bxr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bxr_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int C = bxr_pkg::COORD_BITS;
   localparam int F = OFFSET_FRAC_BITS;
   localparam int PW = bxr_pkg::OFFSET_BITS + C + 1;
   localparam int XW = ((F + 1 > 16) ? (C + F + 1) : (C + 16)) + 2;
   localparam int FW = XW + bxr_pkg::SCALE_BITS + 1;
   localparam int R = F + bxr_pkg::FINE_EXTRA;
   localparam int RW = FW - R + 1;
   localparam int NSTAGE = 9;
   localparam logic signed [XW-1:0] OneF = XW'(1) << F;
   localparam logic signed [FW-1:0] OneFine = FW'(1) << R;

   // configuration registers
   logic [bxr_pkg::IMAGE_BITS-1:0] image_width_ff;
   logic [bxr_pkg::IMAGE_BITS-1:0] image_height_ff;
   logic                           square_mode_ff;
   logic [bxr_pkg::SCALE_BITS-1:0] side_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= bxr_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= bxr_pkg::IMAGE_HEIGHT_RESET;
         square_mode_ff <= 1'b0;
         side_scale_ff <= bxr_pkg::SIDE_SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bxr_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[bxr_pkg::IMAGE_BITS-1:0];
            end
            bxr_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[bxr_pkg::IMAGE_BITS-1:0];
            end
            bxr_pkg::CSR_SQUARE_MODE: begin
               square_mode_ff <= csr_wdata[0];
            end
            bxr_pkg::CSR_SIDE_SCALE: begin
               side_scale_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // handshake and valid line
   logic              busy_ff;
   logic              busy_in;
   logic              accept;
   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;

   assign busy_in = reset;
   assign accept = start && !busy_ff;
   assign valid_in = {valid_ff[NSTAGE-2:0], accept};

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign busy = busy_ff;

   // stage 1: offset times box size
   logic [C-1:0] l1_ff, t1_ff, bw1_ff, bh1_ff;
   logic signed [PW-1:0] pl1_ff, pt1_ff, pr1_ff, pb1_ff;
   logic signed [PW-1:0] pl1_in, pt1_in, pr1_in, pb1_in;

   always_comb begin
      pl1_in = PW'(req_data.offset_left) * PW'($signed({1'b0, req_data.box_width}));
      pr1_in = PW'(req_data.offset_right) * PW'($signed({1'b0, req_data.box_width}));
      pt1_in = PW'(req_data.offset_top) * PW'($signed({1'b0, req_data.box_height}));
      pb1_in = PW'(req_data.offset_bottom) * PW'($signed({1'b0, req_data.box_height}));
   end

   always_ff @(posedge clock) begin
      l1_ff <= req_data.left;
      t1_ff <= req_data.top;
      bw1_ff <= req_data.box_width;
      bh1_ff <= req_data.box_height;
      pl1_ff <= pl1_in;
      pt1_ff <= pt1_in;
      pr1_ff <= pr1_in;
      pb1_ff <= pb1_in;
   end

   // stage 2: edges at offset precision
   logic signed [XW-1:0] x0f2_ff, y0f2_ff, x1f2_ff, y1f2_ff;
   logic signed [XW-1:0] x0f2_in, y0f2_in, x1f2_in, y1f2_in;
   logic [XW-1:0] lz, tz, rz, bz;

   always_comb begin
      lz = XW'(l1_ff);
      tz = XW'(t1_ff);
      rz = XW'(l1_ff) + XW'(bw1_ff);
      bz = XW'(t1_ff) + XW'(bh1_ff);
      x0f2_in = ($signed(lz) <<< F) + XW'(pl1_ff);
      y0f2_in = ($signed(tz) <<< F) + XW'(pt1_ff);
      x1f2_in = ($signed(rz) <<< F) + XW'(pr1_ff);
      y1f2_in = ($signed(bz) <<< F) + XW'(pb1_ff);
   end

   always_ff @(posedge clock) begin
      x0f2_ff <= x0f2_in;
      y0f2_ff <= y0f2_in;
      x1f2_ff <= x1f2_in;
      y1f2_ff <= y1f2_in;
   end

   // stage 3: box size and longer side
   logic signed [XW-1:0] x0f3_ff, y0f3_ff, x1f3_ff, y1f3_ff;
   logic signed [XW-1:0] w3_ff, h3_ff, s3_ff;
   logic signed [XW-1:0] w3_in, h3_in, s3_in;

   always_comb begin
      w3_in = x1f2_ff - x0f2_ff + OneF;
      h3_in = y1f2_ff - y0f2_ff + OneF;
      s3_in = (h3_in > w3_in) ? h3_in : w3_in;
   end

   always_ff @(posedge clock) begin
      x0f3_ff <= x0f2_ff;
      y0f3_ff <= y0f2_ff;
      x1f3_ff <= x1f2_ff;
      y1f3_ff <= y1f2_ff;
      w3_ff <= w3_in;
      h3_ff <= h3_in;
      s3_ff <= s3_in;
   end

   // stage 4: longer side times side scale
   logic signed [XW-1:0] x0f4_ff, y0f4_ff, x1f4_ff, y1f4_ff;
   logic signed [XW-1:0] w4_ff, h4_ff, s4_ff;
   logic signed [FW-1:0] hs4_ff;
   logic signed [FW-1:0] hs4_in;

   assign hs4_in = FW'(s3_ff) * FW'($signed({1'b0, side_scale_ff}));

   always_ff @(posedge clock) begin
      x0f4_ff <= x0f3_ff;
      y0f4_ff <= y0f3_ff;
      x1f4_ff <= x1f3_ff;
      y1f4_ff <= y1f3_ff;
      w4_ff <= w3_ff;
      h4_ff <= h3_ff;
      s4_ff <= s3_ff;
      hs4_ff <= hs4_in;
   end

   // stage 5: corners at fine precision, square reshape when square mode is set
   logic signed [FW-1:0] x05_ff, y05_ff, x15_ff, y15_ff;
   logic signed [FW-1:0] x05_in, y05_in, x15_in, y15_in;
   logic signed [FW-1:0] x0e, y0e, x1e, y1e, wh, hh, sh;

   always_comb begin
      x0e = FW'(x0f4_ff) <<< bxr_pkg::FINE_EXTRA;
      y0e = FW'(y0f4_ff) <<< bxr_pkg::FINE_EXTRA;
      x1e = FW'(x1f4_ff) <<< bxr_pkg::FINE_EXTRA;
      y1e = FW'(y1f4_ff) <<< bxr_pkg::FINE_EXTRA;
      wh = FW'(w4_ff) <<< (bxr_pkg::FINE_EXTRA - 1);
      hh = FW'(h4_ff) <<< (bxr_pkg::FINE_EXTRA - 1);
      sh = FW'(s4_ff) <<< (bxr_pkg::FINE_EXTRA - 1);
      if (square_mode_ff) begin
         x05_in = x0e + wh - sh;
         y05_in = y0e + hh - hs4_ff;
         x15_in = x0e + wh + sh - OneFine;
         y15_in = y0e + hh + hs4_ff - OneFine;
      end else begin
         x05_in = x0e;
         y05_in = y0e;
         x15_in = x1e;
         y15_in = y1e;
      end
   end

   always_ff @(posedge clock) begin
      x05_ff <= x05_in;
      y05_ff <= y05_in;
      x15_ff <= x15_in;
      y15_ff <= y15_in;
   end

   // stages 6 and 7: rounding to whole pixels
   logic signed [RW-1:0] rnd_l, rnd_t, rnd_r, rnd_b;

   bxr_round #(.FW(FW), .SHIFT(R)) u_round_left (
      .clock(clock), .in_value(x05_ff), .out_value(rnd_l)
   );
   bxr_round #(.FW(FW), .SHIFT(R)) u_round_top (
      .clock(clock), .in_value(y05_ff), .out_value(rnd_t)
   );
   bxr_round #(.FW(FW), .SHIFT(R)) u_round_right (
      .clock(clock), .in_value(x15_ff), .out_value(rnd_r)
   );
   bxr_round #(.FW(FW), .SHIFT(R)) u_round_bottom (
      .clock(clock), .in_value(y15_ff), .out_value(rnd_b)
   );

   // stage 8: clamp to the image and to the output range
   logic [14:0] left8_ff, top8_ff, left8_in, top8_in;
   logic signed [15:0] right8_ff, bottom8_ff, right8_in, bottom8_in;
   logic signed [RW-1:0] bound_w, bound_h;

   always_comb begin
      bound_w = $signed(RW'(image_width_ff));
      bound_h = $signed(RW'(image_height_ff));

      if (rnd_l[RW-1]) begin
         left8_in = '0;
      end else if (rnd_l > RW'(32767)) begin
         left8_in = 15'h7fff;
      end else begin
         left8_in = rnd_l[14:0];
      end

      if (rnd_t[RW-1]) begin
         top8_in = '0;
      end else if (rnd_t > RW'(32767)) begin
         top8_in = 15'h7fff;
      end else begin
         top8_in = rnd_t[14:0];
      end

      if (rnd_r >= bound_w) begin
         right8_in = 16'(bound_w - RW'(1));
      end else if (rnd_r < RW'(-32768)) begin
         right8_in = 16'sh8000;
      end else begin
         right8_in = rnd_r[15:0];
      end

      if (rnd_b >= bound_h) begin
         bottom8_in = 16'(bound_h - RW'(1));
      end else if (rnd_b < RW'(-32768)) begin
         bottom8_in = 16'sh8000;
      end else begin
         bottom8_in = rnd_b[15:0];
      end
   end

   always_ff @(posedge clock) begin
      left8_ff <= left8_in;
      top8_ff <= top8_in;
      right8_ff <= right8_in;
      bottom8_ff <= bottom8_in;
   end

   // stage 9: new size with saturation
   bxr_pkg::rsp_type rsp_ff;
   bxr_pkg::rsp_type rsp_in;
   logic signed [16:0] dw, dh;

   always_comb begin
      dw = $signed({right8_ff[15], right8_ff}) - $signed({2'b00, left8_ff});
      dh = $signed({bottom8_ff[15], bottom8_ff}) - $signed({2'b00, top8_ff});
      rsp_in.new_left = left8_ff;
      rsp_in.new_top = top8_ff;
      rsp_in.new_right = right8_ff;
      rsp_in.new_bottom = bottom8_ff;
      if (dw[16] != dw[15]) begin
         rsp_in.new_width = dw[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         rsp_in.new_width = dw[15:0];
      end
      if (dh[16] != dh[15]) begin
         rsp_in.new_height = dh[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         rsp_in.new_height = dh[15:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = valid_ff[NSTAGE-1];

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the box regression refine block
`timescale 1ns / 1ps

// tracks boxes taken by the block and checks each refined box against a prediction
class box_refine_scoreboard;

   localparam int FRAC_BITS = 13;
   localparam int FINE_BITS = FRAC_BITS + 13;
   localparam longint UNIT = longint'(1) <<< FRAC_BITS;
   localparam longint TO_FINE = longint'(1) <<< 13;
   localparam longint ONE_FINE = longint'(1) <<< FINE_BITS;
   localparam longint HALF_FINE = longint'(1) <<< (FINE_BITS - 1);

   // register copies
   bit [bxr_pkg::IMAGE_BITS-1:0] img_w;
   bit [bxr_pkg::IMAGE_BITS-1:0] img_h;
   bit                           square;
   bit [bxr_pkg::SCALE_BITS-1:0] scale;

   bxr_pkg::rsp_type expected_boxes[$];
   int mismatches;
   int boxes_seen;
   int square_boxes;
   int results_checked;

   function new();
      img_w = bxr_pkg::IMAGE_WIDTH_RESET;
      img_h = bxr_pkg::IMAGE_HEIGHT_RESET;
      square = 1'b0;
      scale = bxr_pkg::SIDE_SCALE_RESET;
      mismatches = 0;
      boxes_seen = 0;
      square_boxes = 0;
      results_checked = 0;
   endfunction

   function void write_reg(logic [bxr_pkg::CSR_INDEX_BITS-1:0] idx,
                           logic [bxr_pkg::CSR_DATA_BITS-1:0] data);
      case (idx)
         bxr_pkg::CSR_IMAGE_WIDTH: img_w = data[bxr_pkg::IMAGE_BITS-1:0];
         bxr_pkg::CSR_IMAGE_HEIGHT: img_h = data[bxr_pkg::IMAGE_BITS-1:0];
         bxr_pkg::CSR_SQUARE_MODE: square = data[0];
         bxr_pkg::CSR_SIDE_SCALE: scale = data[bxr_pkg::SCALE_BITS-1:0];
         default: ;
      endcase
   endfunction

   // round half away from zero at the fine fraction point
   function longint round_fine(longint v);
      if (v >= 0) return (v + HALF_FINE) >>> FINE_BITS;
      return -((-v + HALF_FINE) >>> FINE_BITS);
   endfunction

   function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // expected refined box for one input box under the current registers
   function bxr_pkg::rsp_type refine_box(bxr_pkg::req_type b);
      longint l, t, bw, bh;
      longint x0, y0, x1, y1;
      longint w, h, s, hs;
      longint rl, rt, rr, rb, dw, dh;
      bxr_pkg::rsp_type r;
      l = longint'(b.left);
      t = longint'(b.top);
      bw = longint'(b.box_width);
      bh = longint'(b.box_height);
      x0 = (l * UNIT + longint'(b.offset_left) * bw) * TO_FINE;
      y0 = (t * UNIT + longint'(b.offset_top) * bh) * TO_FINE;
      x1 = ((l + bw) * UNIT + longint'(b.offset_right) * bw) * TO_FINE;
      y1 = ((t + bh) * UNIT + longint'(b.offset_bottom) * bh) * TO_FINE;
      // square reshape about the center, height scaled from the longer side
      if (square) begin
         w = x1 - x0 + ONE_FINE;
         h = y1 - y0 + ONE_FINE;
         s = (h > w) ? h : w;
         hs = (s / TO_FINE) * longint'(scale) * 2;
         x0 = x0 + w / 2 - s / 2;
         y0 = y0 + h / 2 - hs / 2;
         x1 = x0 + s - ONE_FINE;
         y1 = y0 + hs - ONE_FINE;
      end
      rl = round_fine(x0);
      rt = round_fine(y0);
      rr = round_fine(x1);
      rb = round_fine(y1);
      // clamp to the image
      if (rl < 0) rl = 0;
      if (rt < 0) rt = 0;
      if (rr >= longint'(img_w)) rr = longint'(img_w) - 1;
      if (rb >= longint'(img_h)) rb = longint'(img_h) - 1;
      rl = clip(rl, 0, 32767);
      rt = clip(rt, 0, 32767);
      rr = clip(rr, -32768, 32767);
      rb = clip(rb, -32768, 32767);
      dw = clip(rr - rl, -32768, 32767);
      dh = clip(rb - rt, -32768, 32767);
      r.new_left = rl[14:0];
      r.new_top = rt[14:0];
      r.new_right = rr[15:0];
      r.new_bottom = rb[15:0];
      r.new_width = dw[15:0];
      r.new_height = dh[15:0];
      return r;
   endfunction

   function void note_box(bxr_pkg::req_type b);
      expected_boxes.push_back(refine_box(b));
      boxes_seen++;
      if (square) square_boxes++;
   endfunction

   function int pending();
      return expected_boxes.size();
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH at result %0d (t=%0t): %s", results_checked, $realtime, msg);
      mismatches++;
   endtask

   task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 16'h%h expected 16'h%h", name, got, want));
   endtask

   task check_box(bxr_pkg::rsp_type got);
      bxr_pkg::rsp_type want;
      if (expected_boxes.size() == 0) begin
         report_mismatch("result with no box outstanding");
         return;
      end
      want = expected_boxes.pop_front();
      check_field("new_left", {1'b0, got.new_left}, {1'b0, want.new_left});
      check_field("new_top", {1'b0, got.new_top}, {1'b0, want.new_top});
      check_field("new_right", got.new_right, want.new_right);
      check_field("new_bottom", got.new_bottom, want.new_bottom);
      check_field("new_width", got.new_width, want.new_width);
      check_field("new_height", got.new_height, want.new_height);
      results_checked++;
   endtask

   task flush_leftovers();
      while (expected_boxes.size() > 0) begin
         void'(expected_boxes.pop_front());
         report_mismatch("box never produced a result");
      end
   endtask

endclass

module tb;

   localparam int RESULT_LATENCY = 9;
   localparam int NUM_PHASES = 8;
   localparam int RANDOM_PER_PHASE = 216;
   localparam int NUM_DIRECTED = 13;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   bxr_pkg::req_type                   req_data = '0;
   logic                               rsp_valid;
   bxr_pkg::rsp_type                   rsp_data;
   logic                               csr_we = 1'b0;
   logic [bxr_pkg::CSR_INDEX_BITS-1:0] csr_index = bxr_pkg::CSR_IMAGE_WIDTH;
   logic [bxr_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   box_refine_scoreboard sb;

   // register settings per phase; phase 0 keeps reset values, phase 6 is random
   int phase_w [NUM_PHASES] = '{640, 640, 0, 8191, 1, 4096, 0, 4096};
   int phase_h [NUM_PHASES] = '{480, 480, 0, 8191, 1, 4096, 0, 1};
   int phase_sq [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1};
   int phase_scale [NUM_PHASES] = '{4096, 4096, 0, 65535, 0, 65535, 0, 2048};

   box_regression_refine_top DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // watch register writes, accepted boxes and results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.note_box(req_data);
         if (rsp_valid) sb.check_box(rsp_data);
      end
   end

   // hard stop
   initial begin
      #5_000_000;
      $display("timeout with %0d boxes outstanding", sb.pending());
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic bxr_pkg::req_type make_box(int l, int t, int bw, int bh,
                                                 int ofl, int oft, int ofr, int ofb);
      bxr_pkg::req_type b;
      b.left = l[bxr_pkg::COORD_BITS-1:0];
      b.top = t[bxr_pkg::COORD_BITS-1:0];
      b.box_width = bw[bxr_pkg::COORD_BITS-1:0];
      b.box_height = bh[bxr_pkg::COORD_BITS-1:0];
      b.offset_left = ofl[bxr_pkg::OFFSET_BITS-1:0];
      b.offset_top = oft[bxr_pkg::OFFSET_BITS-1:0];
      b.offset_right = ofr[bxr_pkg::OFFSET_BITS-1:0];
      b.offset_bottom = ofb[bxr_pkg::OFFSET_BITS-1:0];
      return b;
   endfunction

   // corner boxes: extremes, exact halves both ways, clamping and saturation
   function automatic bxr_pkg::req_type directed_box(int k);
      case (k)
         0: return make_box(0, 0, 0, 0, 0, 0, 0, 0);
         1: return make_box(4095, 4095, 4095, 4095, 0, 0, 0, 0);
         2: return make_box(4095, 4095, 4095, 4095, 32767, 32767, 32767, 32767);
         3: return make_box(4095, 4095, 4095, 4095, -32768, -32768, -32768, -32768);
         4: return make_box(0, 0, 4095, 4095, -32768, -32768, -32768, -32768);
         // positive halves round up
         5: return make_box(100, 50, 3, 5, 4096, 4096, -4096, -4096);
         // negative halves round away from zero on the far edges
         6: return make_box(0, 0, 1, 1, -4096, -4096, -12288, -12288);
         7: return make_box(600, 400, 200, 200, 0, 0, 0, 0);
         8: return make_box(12'hAAA, 12'h555, 12'hAAA, 12'h555,
                            16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
         9: return make_box(12'h555, 12'hAAA, 12'h555, 12'hAAA,
                            16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
         10: return make_box(10, 20, 0, 4095, 1024, -1024, 2048, -2048);
         11: return make_box(20, 10, 4095, 0, -1024, 1024, -2048, 2048);
         default: return make_box(4095, 4095, 4095, 4095, 32767, 32767, 0, 0);
      endcase
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 4095;
         2, 3: return $urandom_range(0, 63);
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   // offsets: small values half the time, otherwise halves, extremes or any 16-bit word
   function automatic int rand_offset();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return (int'($urandom_range(0, 15)) - 8) * 4096;
         3, 4: return $urandom_range(0, 65535);
         default: return int'($urandom_range(0, 8191)) - 4096;
      endcase
   endfunction

   function automatic bxr_pkg::req_type rand_box();
      return make_box(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_offset(), rand_offset(), rand_offset(), rand_offset());
   endfunction

   // present one box and hold it until the block takes it
   task automatic send_box(bxr_pkg::req_type b);
      start <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_for_results();
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   task automatic write_config(int w, int h, int sq, int scl);
      csr_we <= 1'b1;
      csr_index <= bxr_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= w[bxr_pkg::CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_index <= bxr_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= h[bxr_pkg::CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_index <= bxr_pkg::CSR_SQUARE_MODE;
      csr_wdata <= sq[bxr_pkg::CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_index <= bxr_pkg::CSR_SIDE_SCALE;
      csr_wdata <= scl[bxr_pkg::CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // directed boxes run straight into the random ones that follow
   task automatic run_directed();
      for (int k = 0; k < NUM_DIRECTED; k++) send_box(directed_box(k));
   endtask

   // random boxes in bursts with random gaps, now and then draining completely
   task automatic run_random(int count);
      int burst;
      int gap;
      bit drain;
      while (count > 0) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && count > 0) begin
            send_box(rand_box());
            burst--;
            count--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         drain = ($urandom_range(0, 29) == 0);
         if (gap > 0 || drain) start <= 1'b0;
         repeat (gap) @(posedge clock);
         if (drain) wait_for_results();
      end
      start <= 1'b0;
   endtask

   // main sequence
   initial begin
      int settle;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            wait_for_results();
            repeat (RESULT_LATENCY + 3) @(posedge clock);
            if (p == 6) begin
               write_config($urandom_range(1, 4096), $urandom_range(1, 4096),
                            $urandom_range(0, 1), $urandom_range(0, 16384));
            end else begin
               write_config(phase_w[p], phase_h[p], phase_sq[p], phase_scale[p]);
            end
         end
         if (p < 2) run_directed();
         run_random(RANDOM_PER_PHASE);
      end
      // let the pipeline empty, with a bound
      settle = 0;
      while (sb.pending() > 0 && settle < 20 * RESULT_LATENCY) begin
         @(posedge clock);
         settle++;
      end
      repeat (RESULT_LATENCY + 4) @(posedge clock);
      sb.flush_leftovers();
      $display("%0d boxes refined over %0d register settings, %0d in square mode",
               sb.boxes_seen, NUM_PHASES, sb.square_boxes);
      $display("%0d results compared, %0d mismatches", sb.results_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- box_regression_refine_top.f -----
src/bxr_pkg.sv
src/bxr_round.sv
src/box_regression_refine_top.sv
dv/tb.sv
